FILE: rtl/hsl2rgb_pkg.sv
// shared types and fixed-point constants for the hsl to rgb converter
`timescale 1ns / 1ps
`default_nettype none

package hsl2rgb_pkg;

  // unsigned q16 levels, 65536 is one
  localparam int unsigned LevelW = 17;
  localparam int unsigned HueW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [LevelW-1:0] QOne = 17'd65536;
  localparam logic [LevelW-1:0] QHalf = 17'd32768;
  localparam logic [HueW-1:0] QThird = 16'd21845;
  localparam logic [HueW-1:0] QMinusThird = 16'd43691;
  localparam logic [HueW-1:0] QSixth = 16'd10923;
  localparam logic [HueW-1:0] QHalfTurn = 16'd32768;
  localparam logic [HueW-1:0] QTwoThirds = 16'd43690;
  localparam logic [7:0] ByteMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SATURATION = 2'd0,
    CFG_LIGHTNESS  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_e;

  // load enables of the first two stages
  typedef struct packed {
    logic en1;
    logic en2;
  } lvl_ctrl_t;

  // load enables of the three channel stages
  typedef struct packed {
    logic en3;
    logic en4;
    logic en5;
  } chan_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/hsl2rgb_level.sv
// stages one and two: q and p from the registers, and the three shifted hues
`timescale 1ns / 1ps
`default_nettype none

module hsl2rgb_level
  import hsl2rgb_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire lvl_ctrl_t              ctrl_i,
  input  wire logic [LevelW-1:0]      sat_i,
  input  wire logic [LevelW-1:0]      light_i,
  input  wire logic [HueW-1:0]        hue_i,
  output logic      [LevelW-1:0]      q_o,
  output logic      [LevelW-1:0]      p_o,
  output logic      [LevelW-1:0]      d_o,
  output logic      [2:0][HueW-1:0]   t_o
);

  logic              lo;
  logic [17:0]       mult;
  logic [34:0]       prod;
  logic [17:0]       pq_q;
  logic [HueW-1:0]   h1_q;

  logic [18:0]       qa;
  logic [LevelW-1:0] qb;
  logic [LevelW-1:0] qc;
  logic [18:0]       pa;
  logic [LevelW-1:0] pc;
  logic [2:0][HueW-1:0] t_d;

  logic [LevelW-1:0]    q_q;
  logic [LevelW-1:0]    p_q;
  logic [LevelW-1:0]    d_q;
  logic [2:0][HueW-1:0] t_q;

  assign lo   = light_i < QHalf;
  assign mult = lo ? ({1'b0, sat_i} + {1'b0, QOne}) : {1'b0, sat_i};
  assign prod = {18'd0, light_i} * {17'd0, mult};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      pq_q <= prod[33:16];
      h1_q <= hue_i;
    end
  end

  always_comb begin
    qa = lo ? {1'b0, pq_q}
            : ({2'b0, light_i} + {2'b0, sat_i} - {1'b0, pq_q});
    qb = (qa > {2'b0, QOne}) ? QOne : qa[LevelW-1:0];
    qc = (qb < light_i) ? light_i : qb;
    pa = {1'b0, light_i, 1'b0} - {2'b0, qc};
    // a negative or oversize p falls back to q
    pc = (pa[18] || (pa > {2'b0, qc})) ? qc : pa[LevelW-1:0];
    t_d[0] = h1_q + QThird;
    t_d[1] = h1_q;
    t_d[2] = h1_q + QMinusThird;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      q_q <= qc;
      p_q <= pc;
      d_q <= qc - pc;
      t_q <= t_d;
    end
  end

  assign q_o = q_q;
  assign p_o = p_q;
  assign d_o = d_q;
  assign t_o = t_q;

endmodule

`default_nettype wire

FILE: rtl/hsl2rgb_channel.sv
// stages three to five of one color channel: segment, slope product, byte scale
`timescale 1ns / 1ps
`default_nettype none

module hsl2rgb_channel
  import hsl2rgb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire chan_ctrl_t        ctrl_i,
  input  wire logic [HueW-1:0]   t_i,
  input  wire logic [LevelW-1:0] q_i,
  input  wire logic [LevelW-1:0] p_i,
  input  wire logic [LevelW-1:0] d_i,
  output logic      [7:0]        byte_o
);

  seg_e              seg_d;
  logic [HueW-1:0]   x;
  logic [17:0]       m_wide;

  seg_e              seg3_q;
  logic [15:0]       m3_q;
  logic [LevelW-1:0] q3_q;
  logic [LevelW-1:0] p3_q;
  logic [LevelW-1:0] d3_q;

  logic [32:0]       prod;
  seg_e              seg4_q;
  logic [LevelW-1:0] inc4_q;
  logic [LevelW-1:0] q4_q;
  logic [LevelW-1:0] p4_q;

  logic [17:0]       level;
  logic [25:0]       scaled;
  logic [9:0]        byte_raw;
  logic [7:0]        byte_q;

  always_comb begin
    priority if (t_i < QSixth) begin
      seg_d = SEG_RISE;
    end else if (t_i < QHalfTurn) begin
      seg_d = SEG_HIGH;
    end else if (t_i < QTwoThirds) begin
      seg_d = SEG_FALL;
    end else begin
      seg_d = SEG_LOW;
    end
    unique case (seg_d)
      SEG_RISE: x = t_i;
      SEG_FALL: x = QTwoThirds - t_i;
      default:  x = '0;
    endcase
    // times six as two shifts
    m_wide = {x, 2'b0} + {1'b0, x, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en3) begin
      seg3_q <= seg_d;
      m3_q   <= m_wide[15:0];
      q3_q   <= q_i;
      p3_q   <= p_i;
      d3_q   <= d_i;
    end
  end

  assign prod = d3_q * {1'b0, m3_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en4) begin
      seg4_q <= seg3_q;
      inc4_q <= prod[32:16];
      q4_q   <= q3_q;
      p4_q   <= p3_q;
    end
  end

  always_comb begin
    unique case (seg4_q)
      SEG_RISE, SEG_FALL: level = {1'b0, p4_q} + {1'b0, inc4_q};
      SEG_HIGH:           level = {1'b0, q4_q};
      default:            level = {1'b0, p4_q};
    endcase
    // level times 255 as a shift and subtract
    scaled   = {level, 8'b0} - {8'b0, level};
    byte_raw = scaled[25:16];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en5) begin
      byte_q <= (byte_raw > {2'b0, ByteMax}) ? ByteMax : byte_raw[7:0];
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

FILE: rtl/hsl_to_rgb_converter_core.sv
// Top level of the hsl to rgb converter: hue stream in, 8-bit rgb stream out.
// Input channel: in_valid_i / in_stall_o with hue_i, a fraction of a full turn
// over 2^HUE_BITS. Output channel: out_valid_o / out_stall_i with red_o, green_o,
// blue_o. A transfer happens on a rising edge with valid high and stall low.
// Saturation (index 0) and lightness (index 1) are q16 registers written over
// cfg_valid_i / cfg_ready_o; cfg_ready_o is always high, values above one are
// held at one and other indices are dropped. Write them only while no item is
// in flight.
// out_valid_o rises when an accepted item reaches the last register stage, and one
// item per cycle is taken while in_stall_o is low. The five register stages are:
// q and p product, q/p clamp and hue shifts, channel segment, slope multiply,
// byte scaling into the output register.
// Each stage loads when it is empty or the next one loads, so bubbles close up.
// When the receiver stalls, the output holds and the stages fill behind it;
// in_stall_o rises only once all five stages hold an item.
// Reset empties the pipeline and sets saturation to one and lightness to half.
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_converter_core
  import hsl2rgb_pkg::*;
#(
  parameter int unsigned HUE_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [HUE_BITS-1:0] hue_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [7:0]          red_o,
  output logic      [7:0]          green_o,
  output logic      [7:0]          blue_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [LevelW-1:0]   cfg_data_i
);

  localparam int unsigned Stages = 5;

  logic [LevelW-1:0]    sat_q;
  logic [LevelW-1:0]    light_q;
  logic [LevelW-1:0]    cfg_clamped;
  logic [HueW-1:0]      hue16;
  logic [Stages-1:0]    v_q;
  logic [Stages-1:0]    v_d;
  logic [Stages-1:0]    en;
  lvl_ctrl_t            lvl_ctrl;
  chan_ctrl_t           chan_ctrl;
  logic [LevelW-1:0]    q;
  logic [LevelW-1:0]    p;
  logic [LevelW-1:0]    d;
  logic [2:0][HueW-1:0] t;
  logic                 in_xfer;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_clamped = (cfg_data_i > QOne) ? QOne : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q   <= QOne;
      light_q <= QHalf;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SATURATION: sat_q   <= cfg_clamped;
        CFG_LIGHTNESS:  light_q <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // hue brought to a q16 fraction of a turn
  if (HUE_BITS >= HueW) begin : g_hue_trunc
    assign hue16 = hue_i[HUE_BITS-1 -: HueW];
  end else begin : g_hue_pad
    assign hue16 = {hue_i, {(HueW-HUE_BITS){1'b0}}};
  end

  // per-stage load enables, last stage first
  always_comb begin
    en[Stages-1] = !v_q[Stages-1] || !out_stall_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < Stages; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign lvl_ctrl.en1  = en[0];
  assign lvl_ctrl.en2  = en[1];
  assign chan_ctrl.en3 = en[2];
  assign chan_ctrl.en4 = en[3];
  assign chan_ctrl.en5 = en[4];

  hsl2rgb_level u_level (
    .clk_i   (clk_i),
    .ctrl_i  (lvl_ctrl),
    .sat_i   (sat_q),
    .light_i (light_q),
    .hue_i   (hue16),
    .q_o     (q),
    .p_o     (p),
    .d_o     (d),
    .t_o     (t)
  );

  hsl2rgb_channel u_red (
    .clk_i  (clk_i),
    .ctrl_i (chan_ctrl),
    .t_i    (t[0]),
    .q_i    (q),
    .p_i    (p),
    .d_i    (d),
    .byte_o (red_o)
  );

  hsl2rgb_channel u_green (
    .clk_i  (clk_i),
    .ctrl_i (chan_ctrl),
    .t_i    (t[1]),
    .q_i    (q),
    .p_i    (p),
    .d_i    (d),
    .byte_o (green_o)
  );

  hsl2rgb_channel u_blue (
    .clk_i  (clk_i),
    .ctrl_i (chan_ctrl),
    .t_i    (t[2]),
    .q_i    (q),
    .p_i    (p),
    .d_i    (d),
    .byte_o (blue_o)
  );

  assign out_valid_o = v_q[Stages-1];

  // input stalls only with a full pipeline behind a stalled output
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled while a stage was free");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> v_q[0])
    else $error("accepted transfer did not reach stage one");

  a_out_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[Stages-2] && !out_stall_i) |=> out_valid_o)
    else $error("item in stage four not passed to output");

  a_cfg_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sat_q <= QOne) && (light_q <= QOne))
    else $error("configuration register above one");

endmodule

`default_nettype wire

FILE: verif/rgb_stream_checker.sv
// stream checker for the hsl to rgb converter: predicts each pixel and compares it
`timescale 1ns / 1ps

module rgb_stream_checker
  import hsl2rgb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [HueW-1:0]    hue_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LevelW-1:0]  cfg_data_i,
  output int                 outstanding_o,
  output int                 errors_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic [LevelW-1:0] sat_q;
  logic [LevelW-1:0] light_q;
  rgb_t              pixels_due[$];

  function automatic logic [7:0] scale_byte(input logic [63:0] level);
    logic [63:0] prod;
    prod = (level * 64'd255) >> 16;
    return (prod > 64'd255) ? ByteMax : prod[7:0];
  endfunction

  // piecewise channel curve over one turn of shifted hue
  function automatic logic [63:0] channel_level(input logic [HueW-1:0] t,
                                                input logic [63:0] p,
                                                input logic [63:0] q);
    logic [63:0] span;
    logic [63:0] tt;
    span = q - p;
    tt = 64'(t);
    if (t < QSixth) return p + ((span * 64'd6 * tt) >> 16);
    if (t < QHalfTurn) return q;
    if (t < QTwoThirds) return p + ((span * 64'd6 * (64'(QTwoThirds) - tt)) >> 16);
    return p;
  endfunction

  function automatic rgb_t hue_to_rgb(input logic [HueW-1:0] hue,
                                      input logic [LevelW-1:0] sat_reg,
                                      input logic [LevelW-1:0] light_reg);
    logic [63:0]     s;
    logic [63:0]     l;
    logic [63:0]     q;
    logic [63:0]     p;
    logic [HueW-1:0] t_red;
    logic [HueW-1:0] t_blue;
    rgb_t            px;
    s = (sat_reg > QOne) ? 64'(QOne) : 64'(sat_reg);
    l = (light_reg > QOne) ? 64'(QOne) : 64'(light_reg);
    if (s == 64'd0) begin
      px.red = scale_byte(l);
      px.green = px.red;
      px.blue = px.red;
      return px;
    end
    if (l < 64'(QHalf)) q = (l * (64'(QOne) + s)) >> 16;
    else q = l + s - ((l * s) >> 16);
    if (q > 64'(QOne)) q = 64'(QOne);
    if (q < l) q = l;
    p = 64'd2 * l - q;
    if (p > q) p = q;
    // hue shifts wrap modulo one turn in 16 bits
    t_red = hue + QThird;
    t_blue = hue - QThird;
    px.red = scale_byte(channel_level(t_red, p, q));
    px.green = scale_byte(channel_level(hue, p, q));
    px.blue = scale_byte(channel_level(t_blue, p, q));
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      sat_q <= QOne;
      light_q <= QHalf;
      pixels_due.delete();
      outstanding_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SATURATION) sat_q <= cfg_data_i;
        else if (cfg_index_i == CFG_LIGHTNESS) light_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) pixels_due.push_back(hue_to_rgb(hue_i, sat_q, light_q));
      if (out_valid_i && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel r=%0d g=%0d b=%0d", red_i, green_i, blue_i);
          errors_o <= errors_o + 1;
        end else begin
          want = pixels_due.pop_front();
          if (want.red !== red_i) $error("red: expected %0d, got %0d", want.red, red_i);
          if (want.green !== green_i)
            $error("green: expected %0d, got %0d", want.green, green_i);
          if (want.blue !== blue_i) $error("blue: expected %0d, got %0d", want.blue, blue_i);
          if (want !== {red_i, green_i, blue_i}) errors_o <= errors_o + 1;
        end
      end
      outstanding_o <= pixels_due.size();
    end
  end

endmodule

FILE: verif/hsl_to_rgb_converter_core_tb.sv
// testbench top for hsl_to_rgb_converter_core: hue stimulus, config writes and verdict
`timescale 1ns / 1ps

module hsl_to_rgb_converter_core_tb;
  import hsl2rgb_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;
  localparam logic [LevelW-1:0]  RegMax = 17'h1FFFF;
  localparam int                 RandPhases = 8;
  localparam int                 HuesPerPhase = 250;
  localparam int                 DrainCycles = 12;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [HueW-1:0]    hue_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [LevelW-1:0]  cfg_data_i;
  int                 outstanding;
  int                 errors;
  logic               calm;
  int                 hues_sent;
  int                 settings_used;

  hsl_to_rgb_converter_core #(
    .HUE_BITS(HueW)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .hue_i      (hue_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  rgb_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .hue_i        (hue_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .outstanding_o(outstanding),
    .errors_o     (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver side stalls at random unless the calm stretch is on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // after an optional random gap, holds the payload until the transfer edge, leaves valid high
  task automatic send_hue(input logic [HueW-1:0] h);
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      hue_i <= HueW'($urandom_range(0, 65535));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    hue_i <= h;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    hues_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [LevelW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
  endtask

  task automatic set_levels(input logic [LevelW-1:0] sat, input logic [LevelW-1:0] light);
    drain();
    cfg_write(CFG_SATURATION, sat);
    cfg_write(CFG_LIGHTNESS, light);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [LevelW-1:0] pick_level();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return QOne;
      2: return RegMax;
      3: return QHalf;
      4: return QHalf - 17'd1;
      default: return LevelW'($urandom_range(0, 131071));
    endcase
  endfunction

  initial begin
    logic [HueW-1:0] edge_hues[12];
    edge_hues = '{16'd0, 16'hFFFF, QThird, QThird - 16'd1, QSixth, QSixth - 16'd1,
                  QHalfTurn, QHalfTurn - 16'd1, QTwoThirds, QTwoThirds - 16'd1,
                  QMinusThird, 16'd1};
    calm = 1'b0;
    hues_sent = 0;
    settings_used = 1;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    hue_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_SATURATION;
    cfg_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset levels: full color, segment boundaries and the wrap to zero
    foreach (edge_hues[i]) send_hue(edge_hues[i]);
    // gray
    set_levels('0, LevelW'($urandom_range(1, 65535)));
    send_hue(16'd0);
    send_hue(16'hFFFF);
    // registers above one are held at one
    set_levels(RegMax, QOne);
    send_hue(QSixth);
    send_hue(QTwoThirds);
    set_levels(QOne, '0);
    send_hue(QThird);
    send_hue(16'h8000);
    set_levels(QHalf, RegMax);
    send_hue(16'h5555);
    send_hue(16'hAAAA);
    // unused register indices must leave both levels alone
    drain();
    cfg_write(CfgSpareA, '0);
    cfg_write(CfgSpareB, RegMax);
    cfg_valid_i <= 1'b0;
    send_hue(16'h1234);
    send_hue(QMinusThird);

    for (int ph = 0; ph < RandPhases; ph++) begin
      set_levels(pick_level(), pick_level());
      calm <= (ph == 3);
      if (ph % 3 == 1) begin
        drain();
        cfg_write($urandom_range(0, 1) ? CfgSpareA : CfgSpareB,
                  LevelW'($urandom_range(0, 131071)));
        cfg_valid_i <= 1'b0;
      end
      for (int n = 0; n < HuesPerPhase; n++) send_hue(HueW'($urandom_range(0, 65535)));
    end
    calm <= 1'b0;

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("tb: %0d hues through %0d level settings, incl. gray, clamped and unused writes",
             hues_sent, settings_used);
    $display("tb: random gaps and stalls on both streams, one phase without them");
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
